// File: hw/rtl/frr_pkg.sv
// ----------------------------------------------------------------------------
// frr_pkg
// shared widths, defaults, function codes and state type of the recycle ring
// ----------------------------------------------------------------------------
`default_nettype none

package frr_pkg;

  localparam int SIZE_W          = 32;
  localparam int ALIGN_W         = 16;
  localparam int DEF_POOL_DEPTH  = 64;
  localparam int DEF_ADDR_WIDTH  = 48;

  // func codes
  localparam logic FUNC_RECYCLE = 1'b0;
  localparam logic FUNC_REUSE   = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RECYCLE,
    ST_SEARCH
  } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/frr_ram.sv
// ----------------------------------------------------------------------------
// frr_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module frr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/freed_block_recycle_ring.sv
// ----------------------------------------------------------------------------
// freed_block_recycle_ring
// ring of freed blocks kept in one ram; recycle writes at the write pointer,
// reuse walks backward one entry per cycle looking for a free match
// ----------------------------------------------------------------------------
// timing: recycle goes through the RECYCLE state, then the done register; a size
//   below min_size gives its word in the cycle after accept; reuse reads one ring
//   entry per cycle from the ram read port and gives its word from the done register
//   once the search stops; no new command is taken while busy is high
// reset: a clearing pass zeroes every ram slot with busy high; min_size config
//   writes are taken during it; the receiver cannot stall
`default_nettype none

module freed_block_recycle_ring #(
  parameter int POOL_DEPTH = frr_pkg::DEF_POOL_DEPTH,
  parameter int ADDR_WIDTH = frr_pkg::DEF_ADDR_WIDTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // command side
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        func,
  input  wire logic [ADDR_WIDTH-1:0]       block_addr,
  input  wire logic [frr_pkg::SIZE_W-1:0]  block_size,
  input  wire logic [frr_pkg::ALIGN_W-1:0] align,
  // config register
  input  wire logic                        min_size_we,
  input  wire logic [frr_pkg::SIZE_W-1:0]  min_size_wdata,
  // result side
  output logic                             done,
  output logic                             accepted,
  output logic                             found,
  output logic [ADDR_WIDTH-1:0]            found_addr,
  output logic                             evict_valid,
  output logic [ADDR_WIDTH-1:0]            evict_addr
);

  import frr_pkg::*;

  localparam int PTR_W   = $clog2(POOL_DEPTH);
  // entry layout: {addr, size, align, in_use}
  localparam int ENTRY_W = ADDR_WIDTH + SIZE_W + ALIGN_W + 1;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(POOL_DEPTH - 1);

  state_t state, state_next;

  logic [PTR_W-1:0]  write_ptr;
  logic [PTR_W-1:0]  clr_idx;    // clearing pass index
  logic [PTR_W-1:0]  idx;        // slot whose data sits on the ram output
  logic [PTR_W-1:0]  left;       // slots still to visit, including idx
  logic [SIZE_W-1:0] min_size;

  // latched command word
  logic [ADDR_WIDTH-1:0] req_addr;
  logic [SIZE_W-1:0]     req_size;
  logic [ALIGN_W-1:0]    req_align;

  // ram ports
  logic               ram_we;
  logic [PTR_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [PTR_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  // result next values
  logic                  res_load;
  logic                  accepted_next;
  logic                  found_next;
  logic [ADDR_WIDTH-1:0] found_addr_next;
  logic                  evict_valid_next;
  logic [ADDR_WIDTH-1:0] evict_addr_next;

  logic take;
  logic size_ok;
  logic [PTR_W-1:0] prev_wp;
  logic [PTR_W-1:0] prev_idx;
  logic [PTR_W-1:0] next_wp;

  // fields of the entry on the ram output
  logic [ADDR_WIDTH-1:0] rd_addr;
  logic [SIZE_W-1:0]     rd_size;
  logic [ALIGN_W-1:0]    rd_align;
  logic                  rd_in_use;
  logic                  rd_empty;
  logic                  rd_match;

  assign busy    = (state != ST_IDLE);
  assign take    = start && !busy;
  assign size_ok = (block_size >= min_size);

  // ring neighbors, wrap works for any depth
  assign prev_wp  = (write_ptr == '0) ? LAST_SLOT : write_ptr - PTR_W'(1);
  assign prev_idx = (idx == '0) ? LAST_SLOT : idx - PTR_W'(1);
  assign next_wp  = (write_ptr == LAST_SLOT) ? '0 : write_ptr + PTR_W'(1);

  assign rd_addr   = ram_rdata[ENTRY_W-1 -: ADDR_WIDTH];
  assign rd_size   = ram_rdata[SIZE_W+ALIGN_W -: SIZE_W];
  assign rd_align  = ram_rdata[ALIGN_W -: ALIGN_W];
  assign rd_in_use = ram_rdata[0];
  assign rd_empty  = (rd_addr == '0);
  // a free entry with the same size and alignment
  assign rd_match  = !rd_empty && (rd_size == req_size) && (rd_align == req_align) &&
                     !rd_in_use;

  frr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (POOL_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_idx == LAST_SLOT) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (take && size_ok) begin
          state_next = (func == FUNC_REUSE) ? ST_SEARCH : ST_RECYCLE;
        end
      end
      ST_RECYCLE: begin
        state_next = ST_IDLE;
      end
      ST_SEARCH: begin
        // stop at an empty entry, a hit, or after the last slot of the lap
        if (rd_empty || rd_match || left == PTR_W'(1)) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  // ram control and result values
  always_comb begin
    ram_we           = 1'b0;
    ram_waddr        = write_ptr;
    ram_wdata        = '0;
    ram_raddr        = write_ptr;
    res_load         = 1'b0;
    accepted_next    = 1'b0;
    found_next       = 1'b0;
    found_addr_next  = '0;
    evict_valid_next = 1'b0;
    evict_addr_next  = '0;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
      end
      ST_IDLE: begin
        // reuse starts just below the write pointer, recycle reads the slot it replaces
        ram_raddr = (func == FUNC_REUSE) ? prev_wp : write_ptr;
        if (take && !size_ok) begin
          res_load = 1'b1;
        end
      end
      ST_RECYCLE: begin
        ram_we        = 1'b1;
        ram_waddr     = write_ptr;
        ram_wdata     = {req_addr, req_size, req_align, 1'b0};
        res_load      = 1'b1;
        accepted_next = 1'b1;
        if (!rd_empty && !rd_in_use) begin
          evict_valid_next = 1'b1;
          evict_addr_next  = rd_addr;
        end
      end
      ST_SEARCH: begin
        // next slot is read speculatively every cycle
        ram_raddr = prev_idx;
        if (rd_match) begin
          ram_we          = 1'b1;
          ram_waddr       = idx;
          ram_wdata       = {ram_rdata[ENTRY_W-1:1], 1'b1};
          res_load        = 1'b1;
          found_next      = 1'b1;
          found_addr_next = rd_addr;
        end else if (rd_empty || left == PTR_W'(1)) begin
          res_load = 1'b1;
        end
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      write_ptr <= '0;
      clr_idx   <= '0;
      min_size  <= '0;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= res_load;
      if (min_size_we) begin
        min_size <= min_size_wdata;
      end
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + PTR_W'(1);
      end
      if (state == ST_RECYCLE) begin
        write_ptr <= next_wp;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (take) begin
      req_addr  <= block_addr;
      req_size  <= block_size;
      req_align <= align;
      idx       <= prev_wp;
      left      <= LAST_SLOT;
    end else if (state == ST_SEARCH) begin
      idx  <= prev_idx;
      left <= left - PTR_W'(1);
    end
    if (res_load) begin
      accepted    <= accepted_next;
      found       <= found_next;
      found_addr  <= found_addr_next;
      evict_valid <= evict_valid_next;
      evict_addr  <= evict_addr_next;
    end
  end

endmodule

`default_nettype wire
